### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL. Defining ASSERT_OFF
// leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant violated");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Field widths, command and result codes, the table entry type, the cell
// operation codes and the controller states.
// ----------------------------------------------------------------------------
package swt_pkg;

   localparam int unsigned ID_W     = 8;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned CTR_W    = 16;
   localparam int unsigned RES_W    = 16;
   localparam int unsigned MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [CTR_W-1:0]    counter;
      logic                one_shot;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_INC,
      OP_ROTATE,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        clear;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INC,
      ST_SCAN
   } state_type;

endpackage

### hw/rtl/swt_cell.sv
// ----------------------------------------------------------------------------
// Software timer table cell
// Holds one table entry. Depending on the broadcast operation it loads a new
// timer, advances its counter, or takes the entry of its upper neighbour, of
// the head cell or of the back of the unscanned region.
// ----------------------------------------------------------------------------
module swt_cell
   import swt_pkg::*;
#(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 4
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [CNT_W-1:0] active_count,
   input  logic [CNT_W-1:0] unprocessed,
   input  entry_type        new_entry,
   input  entry_type        next_entry,
   input  entry_type        head_entry,
   input  entry_type        back_entry,
   output entry_type        entry
);

   localparam logic [CNT_W:0] POS      = (CNT_W + 1)'(INDEX);
   localparam logic [CNT_W:0] POS_NEXT = (CNT_W + 1)'(INDEX + 1);

   entry_type        entry_ff;
   entry_type        entry_in;
   logic [CNT_W:0]   count_ext;
   logic [CNT_W:0]   unproc_ext;

   assign count_ext  = {1'b0, active_count};
   assign unproc_ext = {1'b0, unprocessed};

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (count_ext == POS) begin
               entry_in = new_entry;
            end
         end
         OP_INC: begin
            if (entry_ff.counter != '1) begin
               entry_in.counter = entry_ff.counter + CTR_W'(1);
            end
         end
         OP_ROTATE: begin
            if (count_ext == POS_NEXT) begin
               entry_in = head_entry;
               if (ctrl.clear) begin
                  entry_in.counter = '0;
               end
            end else if (count_ext > POS_NEXT) begin
               entry_in = next_entry;
            end
         end
         OP_REMOVE: begin
            if ((unproc_ext <= POS_NEXT) && (count_ext > POS_NEXT)) begin
               entry_in = next_entry;
            end else if (INDEX == 0) begin
               entry_in = back_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// Software timer table
// Up to NUM_TIMERS software timers held in a chain of cells. Start appends a
// timer, stop removes the first entry with an id, and prescaled overflow
// ticks advance every counter and dispatch the timers that are due.
//
//   Channel  Ports           Word
//   input    req_*           mode, callback_id, period, one_shot
//   result   rsp_*           kind, status, fired_id, last
//   config   csr_wr_*        tick_resolution, written at once
//
// An overflow tick without a prescaled tick only advances the overflow count.
// A start loads a cell unless the table is full and queues its acknowledge.
// A stop steps every entry through the head cell, removing the first match.
// A prescaled tick increments every counter, steps each entry through the
// head cell and hands over the last result. A result still waiting in the
// output register stalls the scan when a further timer fires, and holds back
// the final hand-over until it leaves. Reset clears the control state at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module software_timer_table
   import swt_pkg::*;
#(
   parameter int unsigned NUM_TIMERS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_callback_id,
   input  logic [PERIOD_W-1:0] req_period,
   input  logic                req_one_shot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic                rsp_status,
   output logic [ID_W-1:0]     rsp_fired_id,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [RES_W-1:0]    csr_wr_data
);

   localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   active_count_ff;
   logic [CNT_W-1:0]   active_count_in;
   logic [CNT_W-1:0]   unproc_ff;
   logic [CNT_W-1:0]   unproc_in;
   logic               stop_mode_ff;
   logic               stop_mode_in;
   logic               found_ff;
   logic               found_in;
   logic               pend_valid_ff;
   logic               pend_valid_in;
   logic               pend_kind_ff;
   logic               pend_kind_in;
   logic               pend_status_ff;
   logic               pend_status_in;
   logic [ID_W-1:0]    pend_id_ff;
   logic [ID_W-1:0]    pend_id_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_kind_ff;
   logic               rsp_kind_in;
   logic               rsp_status_ff;
   logic               rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [ID_W-1:0]    rsp_id_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic [RES_W-1:0]   ovf_count_ff;
   logic [RES_W-1:0]   ovf_count_in;
   logic [RES_W-1:0]   tick_res_ff;
   logic [RES_W-1:0]   tick_res_in;

   entry_type          cell_q [NUM_TIMERS];
   entry_type          head_entry;
   entry_type          back_entry;
   entry_type          new_entry;
   cell_ctrl_type      cell_ctrl;

   logic               accept;
   logic               out_free;
   logic               head_fire;
   logic               scan_done;
   logic               table_full;
   logic               prescale;
   logic [RES_W-1:0]   tick_res_eff;
   logic [RES_W-1:0]   ovf_next;
   logic [CNT_W-1:0]   unproc_m1;
   logic [IDX_W-1:0]   back_idx;
   logic               step;
   logic               pend_to_rsp;
   logic               pend_last;
   logic               capture_fire;

   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign scan_done  = (unproc_ff == '0);
   assign table_full = (active_count_ff == CNT_W'(NUM_TIMERS));

   assign tick_res_eff = (tick_res_ff == '0) ? RES_W'(1) : tick_res_ff;
   assign ovf_next     = ovf_count_ff + RES_W'(1);
   assign prescale     = (ovf_next >= tick_res_eff);

   assign head_entry = cell_q[0];
   assign unproc_m1  = unproc_ff - CNT_W'(1);
   assign back_idx   = unproc_m1[IDX_W-1:0];
   assign back_entry = cell_q[back_idx];
   assign head_fire  = (head_entry.counter >= head_entry.period) &&
                       ({1'b0, head_entry.counter} <= {head_entry.period, 1'b0});

   assign new_entry = '{id: req_callback_id, period: req_period, counter: '0,
                        one_shot: req_one_shot};

   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
      entry_type next_entry;
      if (k < NUM_TIMERS - 1) begin : g_mid
         assign next_entry = cell_q[k+1];
      end else begin : g_top
         assign next_entry = cell_q[k];
      end
      swt_cell #(
         .INDEX (k),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .active_count (active_count_ff),
         .unprocessed  (unproc_ff),
         .new_entry    (new_entry),
         .next_entry   (next_entry),
         .head_entry   (head_entry),
         .back_entry   (back_entry),
         .entry        (cell_q[k])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_TICK) && prescale) begin
               state_in = ST_INC;
            end else if (accept && ((req_mode == MODE_START) || (req_mode == MODE_STOP))) begin
               state_in = ST_SCAN;
            end
         end
         ST_INC: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done && (!pend_valid_ff || out_free)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cell_ctrl.op    = OP_HOLD;
      cell_ctrl.clear = 1'b0;
      step            = 1'b0;
      pend_to_rsp     = 1'b0;
      pend_last       = 1'b0;
      capture_fire    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_mode == MODE_START) && !table_full) begin
               cell_ctrl.op = OP_LOAD;
            end
         end
         ST_INC: begin
            cell_ctrl.op = OP_INC;
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (pend_valid_ff && out_free) begin
                  pend_to_rsp = 1'b1;
                  pend_last   = 1'b1;
               end
            end else if (stop_mode_ff) begin
               step = 1'b1;
               if (!found_ff && (head_entry.id == pend_id_ff)) begin
                  cell_ctrl.op = OP_REMOVE;
               end else begin
                  cell_ctrl.op = OP_ROTATE;
               end
            end else if (head_fire) begin
               if (!pend_valid_ff || out_free) begin
                  step            = 1'b1;
                  capture_fire    = 1'b1;
                  pend_to_rsp     = pend_valid_ff;
                  cell_ctrl.clear = 1'b1;
                  if (head_entry.one_shot) begin
                     cell_ctrl.op = OP_REMOVE;
                  end else begin
                     cell_ctrl.op = OP_ROTATE;
                  end
               end
            end else begin
               step         = 1'b1;
               cell_ctrl.op = OP_ROTATE;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      active_count_in = active_count_ff;
      unproc_in       = unproc_ff;
      stop_mode_in    = stop_mode_ff;
      found_in        = found_ff;
      pend_valid_in   = pend_valid_ff;
      pend_kind_in    = pend_kind_ff;
      pend_status_in  = pend_status_ff;
      pend_id_in      = pend_id_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_last_in     = rsp_last_ff;
      ovf_count_in    = ovf_count_ff;
      tick_res_in     = tick_res_ff;

      if (csr_wr_en) begin
         tick_res_in = csr_wr_data;
      end

      if (accept) begin
         unique case (req_mode)
            MODE_TICK: begin
               ovf_count_in = prescale ? '0 : ovf_next;
            end
            MODE_START: begin
               pend_valid_in  = 1'b1;
               pend_kind_in   = KIND_ACK;
               pend_status_in = table_full ? STATUS_FULL : STATUS_OK;
               pend_id_in     = req_callback_id;
               unproc_in      = '0;
               stop_mode_in   = 1'b0;
               if (!table_full) begin
                  active_count_in = active_count_ff + CNT_W'(1);
               end
            end
            MODE_STOP: begin
               pend_valid_in  = 1'b1;
               pend_kind_in   = KIND_ACK;
               pend_status_in = STATUS_OK;
               pend_id_in     = req_callback_id;
               unproc_in      = active_count_ff;
               stop_mode_in   = 1'b1;
               found_in       = 1'b0;
            end
            default: begin
               ovf_count_in = ovf_count_ff;
            end
         endcase
      end

      if (state_ff == ST_INC) begin
         unproc_in    = active_count_ff;
         stop_mode_in = 1'b0;
      end

      if (step) begin
         unproc_in = unproc_m1;
      end

      if (cell_ctrl.op == OP_REMOVE) begin
         active_count_in = active_count_ff - CNT_W'(1);
         found_in        = 1'b1;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_to_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = pend_kind_ff;
         rsp_status_in = pend_status_ff;
         rsp_id_in     = pend_id_ff;
         rsp_last_in   = pend_last;
         pend_valid_in = 1'b0;
      end

      if (capture_fire) begin
         pend_valid_in  = 1'b1;
         pend_kind_in   = KIND_FIRED;
         pend_status_in = STATUS_OK;
         pend_id_in     = head_entry.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_count_ff <= '0;
         unproc_ff       <= '0;
         stop_mode_ff    <= 1'b0;
         found_ff        <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         ovf_count_ff    <= '0;
         tick_res_ff     <= RES_W'(1);
      end else begin
         state_ff        <= state_in;
         active_count_ff <= active_count_in;
         unproc_ff       <= unproc_in;
         stop_mode_ff    <= stop_mode_in;
         found_ff        <= found_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         ovf_count_ff    <= ovf_count_in;
         tick_res_ff     <= tick_res_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff   <= pend_kind_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, active_count_ff <= CNT_W'(NUM_TIMERS))
   `ASSERT_ALWAYS(a_unproc_within_table, clock, reset, unproc_ff <= active_count_ff)
   `ASSERT_IMPLY(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   `ASSERT_NEXT(a_remove_shrinks, clock, reset, cell_ctrl.op == OP_REMOVE, active_count_ff == $past(active_count_ff) - CNT_W'(1))

endmodule

### tb/timer_dispatch_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer dispatch checker
// Watches the command, result and register ports of the software timer table.
// It keeps its own copy of the timer slots, the overflow count and the tick
// resolution. For every accepted command word it works out the acknowledge or
// the fired timers. Each accepted result word is compared with the oldest of
// these, field by field.
// ----------------------------------------------------------------------------
module timer_dispatch_check
   import swt_pkg::*;
#(
   parameter int unsigned NUM_TIMERS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_callback_id,
   input  logic [PERIOD_W-1:0] req_period,
   input  logic                req_one_shot,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_kind,
   input  logic                rsp_status,
   input  logic [ID_W-1:0]     rsp_fired_id,
   input  logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [RES_W-1:0]    csr_wr_data,
   output int                  words_due,
   output int                  error_count
);

   typedef struct packed {
      logic            kind;
      logic            status;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } result_word_type;

   entry_type        slots [NUM_TIMERS];
   int unsigned      n_active = 0;
   logic [RES_W-1:0] overflows = '0;
   logic [RES_W-1:0] resolution = RES_W'(1);
   result_word_type  due_words [$];
   int               mismatches = 0;

   task automatic drop_slot(input int unsigned slot);
      slots[slot] = slots[n_active - 1];
      n_active--;
   endtask

   task automatic advance_timer_table(input logic [MODE_W-1:0] w_mode,
                                      input logic [ID_W-1:0] w_id,
                                      input logic [PERIOD_W-1:0] w_period,
                                      input logic w_one_shot);
      result_word_type fired [$];
      int unsigned     i;
      int unsigned     step;
      logic            hit;
      case (w_mode)
         MODE_START: begin
            if (n_active < NUM_TIMERS) begin
               slots[n_active] = '{id: w_id, period: w_period, counter: '0,
                                   one_shot: w_one_shot};
               n_active++;
               due_words.push_back('{KIND_ACK, STATUS_OK, w_id, 1'b1});
            end else begin
               due_words.push_back('{KIND_ACK, STATUS_FULL, w_id, 1'b1});
            end
         end
         MODE_STOP: begin
            hit = 1'b0;
            for (i = 0; i < n_active; i++) begin
               if (!hit && slots[i].id == w_id) begin
                  drop_slot(i);
                  hit = 1'b1;
               end
            end
            due_words.push_back('{KIND_ACK, STATUS_OK, w_id, 1'b1});
         end
         MODE_TICK: begin
            step = (resolution == 0) ? 1 : resolution;
            overflows = overflows + 1'b1;
            if (overflows >= step) begin
               overflows = '0;
               for (i = 0; i < n_active; i++) begin
                  if (slots[i].counter != '1)
                     slots[i].counter = slots[i].counter + 1'b1;
               end
               // A slot refilled by the swap is looked at again before moving on.
               i = 0;
               while (i < n_active) begin
                  if (slots[i].counter >= slots[i].period &&
                      {1'b0, slots[i].counter} <= {slots[i].period, 1'b0}) begin
                     slots[i].counter = '0;
                     fired.push_back('{KIND_FIRED, STATUS_OK, slots[i].id, 1'b0});
                     if (slots[i].one_shot)
                        drop_slot(i);
                     else
                        i++;
                  end else begin
                     i++;
                  end
               end
               if (fired.size() > 0)
                  fired[fired.size() - 1].last = 1'b1;
               foreach (fired[k])
                  due_words.push_back(fired[k]);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_word();
      result_word_type want;
      if (due_words.size() == 0) begin
         $error("unexpected result word: kind %0d, fired_id %0d", rsp_kind, rsp_fired_id);
         mismatches++;
      end else begin
         want = due_words.pop_front();
         if (rsp_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
            mismatches++;
         end
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            mismatches++;
         end
         if (rsp_fired_id !== want.fired_id) begin
            $error("fired_id: expected %0d, got %0d", want.fired_id, rsp_fired_id);
            mismatches++;
         end
         if (rsp_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         n_active = 0;
         overflows = '0;
         resolution = RES_W'(1);
         due_words.delete();
      end else begin
         if (csr_wr_en)
            resolution = csr_wr_data;
         if (rsp_valid && rsp_ready)
            compare_word();
         if (req_valid && req_ready)
            advance_timer_table(req_mode, req_callback_id, req_period, req_one_shot);
      end
      words_due <= due_words.size();
      error_count <= mismatches;
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives start, stop and overflow tick words into the timer table, with a
// directed opening, a few ticks over the two timers that never fire, and
// random phases under several tick resolutions and handshake pressures.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
   import swt_pkg::*;

   localparam int unsigned NUM_TIMERS = 8;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned LATE_TICKS = 3;
   localparam int unsigned PHASE_WORDS = 44;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [ID_W-1:0]     req_callback_id;
   logic [PERIOD_W-1:0] req_period;
   logic                req_one_shot;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_kind;
   logic                rsp_status;
   logic [ID_W-1:0]     rsp_fired_id;
   logic                rsp_last;
   logic                csr_wr_en;
   logic [RES_W-1:0]    csr_wr_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int words_due;
   int error_count;
   int phase_res [4] = '{1, 2, 1, 3};
   int phase_idle [4] = '{0, 56, 0, 28};
   int phase_stall [4] = '{0, 0, 56, 28};

   software_timer_table #(.NUM_TIMERS(NUM_TIMERS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_callback_id (req_callback_id),
      .req_period      (req_period),
      .req_one_shot    (req_one_shot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   timer_dispatch_check #(.NUM_TIMERS(NUM_TIMERS)) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_callback_id (req_callback_id),
      .req_period      (req_period),
      .req_one_shot    (req_one_shot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .words_due       (words_due),
      .error_count     (error_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                            input logic [PERIOD_W-1:0] per, input logic os);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_callback_id <= id;
      req_period <= per;
      req_one_shot <= os;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_tick();
      send_word(MODE_TICK, ID_W'($urandom), PERIOD_W'($urandom), 1'($urandom));
   endtask

   task automatic send_random();
      int                  pick;
      logic [MODE_W-1:0]   m;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] per;
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0: per = '0;
         1: per = PERIOD_W'($urandom);
         default: per = PERIOD_W'($urandom_range(1, 5));
      endcase
      if (pick < 55)
         m = MODE_TICK;
      else if (pick < 75)
         m = MODE_START;
      else if (pick < 93)
         m = MODE_STOP;
      else
         m = MODE_SPARE;
      send_word(m, id, per, 1'($urandom));
   endtask

   // Waits for every outstanding result, then lets a silent scan run out.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_resolution(input logic [RES_W-1:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_TICK;
      req_callback_id = '0;
      req_period = '0;
      req_one_shot = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(MODE_TICK, 8'hFF, 16'hFFFF, 1'b1);
      send_word(MODE_START, 8'h00, 16'd1, 1'b0);
      send_word(MODE_START, 8'hFF, 16'd0, 1'b0);
      send_word(MODE_START, 8'h5A, 16'd2, 1'b1);
      send_word(MODE_START, 8'h5A, 16'd3, 1'b0);
      send_word(MODE_START, 8'hA5, 16'hFFFF, 1'b0);
      send_word(MODE_START, 8'h07, 16'd1, 1'b1);
      send_word(MODE_START, 8'h09, 16'd2, 1'b0);
      send_word(MODE_START, 8'h33, 16'd4, 1'b1);
      send_word(MODE_START, 8'h44, 16'd1, 1'b0);
      send_word(MODE_SPARE, 8'hC3, 16'h5555, 1'b1);
      repeat (3) send_tick();
      send_word(MODE_STOP, 8'h5A, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h99, 16'd0, 1'b0);
      repeat (2) send_tick();
      set_resolution(16'd5);
      repeat (4) send_tick();
      set_resolution(16'd2);
      send_tick();
      set_resolution(16'd0);
      repeat (2) send_tick();
      set_resolution(16'hFFFF);
      repeat (2) send_tick();

      // Leave only the zero period timer and the longest period timer, then
      // tick a few times over them.
      send_word(MODE_STOP, 8'h00, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h5A, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h5A, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h07, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h09, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'h33, 16'd0, 1'b0);
      set_resolution(16'd1);
      repeat (LATE_TICKS) send_tick();
      send_word(MODE_STOP, 8'hFF, 16'd0, 1'b0);
      send_word(MODE_STOP, 8'hA5, 16'd0, 1'b0);

      for (int ph = 0; ph < 4; ph++) begin
         set_resolution(RES_W'(phase_res[ph]));
         idle_pct = phase_idle[ph];
         stall_pct = phase_stall[ph];
         repeat (PHASE_WORDS) send_random();
      end

      settle();
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/swt_pkg.sv
hw/rtl/swt_cell.sv
hw/rtl/software_timer_table.sv
tb/timer_dispatch_check.sv
tb/tb_top.sv
